// ----- design/two_class_priority_message_queue_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the two-class priority message queue
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_MESSAGE_QUEUE_MACROS_SVH
`define TWO_CLASS_PRIORITY_MESSAGE_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent holds in a cycle -> consequent holds in that same cycle.
`define TCPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcpq: same-cycle implication failed");
// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define TCPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcpq: next-cycle implication failed");
`else
`define TCPQ_ASSERT_IMP(lbl, ante, cons)
`define TCPQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/tcpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the two-class priority message queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  // Default geometry
  localparam int unsigned NORMAL_DEPTH_DEF = 16;
  localparam int unsigned URGENT_DEPTH_DEF = 8;
  localparam int unsigned DATA_WIDTH_DEF   = 32;

  // Fixed field widths
  localparam int unsigned OPCODE_W      = 3;
  localparam int unsigned PAYLOAD_W     = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned NLIMIT_W      = 5;
  localparam int unsigned ULIMIT_W      = 4;
  localparam int unsigned FREE_TOTAL_W  = 5;
  localparam int unsigned FREE_URGENT_W = 4;
  localparam int unsigned FREE_NORMAL_W = 5;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 5;

  // Register reset values
  localparam logic [NLIMIT_W-1:0] NLIMIT_RST = NLIMIT_W'(16);
  localparam logic [ULIMIT_W-1:0] ULIMIT_RST = ULIMIT_W'(8);

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_LIMIT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_URGENT_LIMIT = CFG_INDEX_W'(1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_SEND_NORMAL  = 3'd0,
    OP_SEND_URGENT  = 3'd1,
    OP_RECEIVE      = 3'd2,
    OP_FLUSH_NORMAL = 3'd3,
    OP_FLUSH_URGENT = 3'd4,
    OP_FLUSH_ALL    = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Per-cycle command to one ring store
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctrl_t;

endpackage

// ----- design/two_class_priority_message_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_message_queue
// Message queue with an urgent and a normal class, each first in, first out,
// each with its own occupancy limit. Receives drain urgent first.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Carries
//  -------  ---------  ----------------------  ------------------------------
//  in       sink       in_valid_i / in_stall_o opcode_i, payload_i
//  out      source     out_valid_o/out_stall_i status_o, message_out_o,
//                                              is_urgent_out_o, free_*_o
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  One operation per cycle sustained while out_stall_i does not hold the
//  result register; each transaction is taken into the input register and
//  its result is presented from the result register.
//  The rate is set by the update of ring pointers and counts per operation.
//  Reset zeroes pointers and counts and loads the limits with their defaults
//  at once; no clearing pass runs, as store entries are only read after
//  being written.
//  in_stall_o rises only when the input register is full and the result
//  register is held by out_stall_i. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`include "two_class_priority_message_queue_macros.svh"

module two_class_priority_message_queue #(
  parameter int unsigned NORMAL_DEPTH = tcpq_pkg::NORMAL_DEPTH_DEF,
  parameter int unsigned URGENT_DEPTH = tcpq_pkg::URGENT_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH   = tcpq_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Operation channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tcpq_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [tcpq_pkg::PAYLOAD_W-1:0]      payload_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tcpq_pkg::STATUS_W-1:0]       status_o,
  output logic [tcpq_pkg::PAYLOAD_W-1:0]      message_out_o,
  output logic                                is_urgent_out_o,
  output logic [tcpq_pkg::FREE_TOTAL_W-1:0]   free_total_o,
  output logic [tcpq_pkg::FREE_URGENT_W-1:0]  free_urgent_o,
  output logic [tcpq_pkg::FREE_NORMAL_W-1:0]  free_normal_o,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tcpq_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [tcpq_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import tcpq_pkg::*;

  localparam int unsigned NCW  = $clog2(NORMAL_DEPTH + 1);
  localparam int unsigned UCW  = $clog2(URGENT_DEPTH + 1);
  localparam int unsigned MW0  = (NCW > UCW) ? NCW : UCW;
  // Working width for limits, counts and their sums
  localparam int unsigned SW   = ((MW0 > NLIMIT_W) ? MW0 : NLIMIT_W) + 1;
  localparam int unsigned WIDE = 64;

  // ---------------- configuration registers ----------------
  logic [NLIMIT_W-1:0] normal_limit_q;
  logic [ULIMIT_W-1:0] urgent_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_limit_q <= NLIMIT_RST;
      urgent_limit_q <= ULIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // Writes to indexes outside the register list are dropped
      unique case (cfg_index_i)
        REG_NORMAL_LIMIT: normal_limit_q <= cfg_data_i;
        REG_URGENT_LIMIT: urgent_limit_q <= cfg_data_i[ULIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic                 in_valid_q;
  op_e                  in_op_q;
  logic [PAYLOAD_W-1:0] in_payload_q;
  logic                 advance;   // result register can take a new result
  logic                 fire;      // operation executes this cycle

  logic                 out_valid_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_op_q      <= op_e'(opcode_i);
      in_payload_q <= payload_i;
    end
  end

  // ---------------- ring stores ----------------
  ring_ctrl_t            n_ctrl, u_ctrl;
  logic [NCW-1:0]        n_count;
  logic [UCW-1:0]        u_count;
  logic [DATA_WIDTH-1:0] n_rdata, u_rdata;
  logic [DATA_WIDTH-1:0] wdata;
  logic [WIDE-1:0]       payload_wide;

  // Sent word keeps its low DATA_WIDTH bits (zero-extended if wider)
  assign payload_wide = WIDE'(in_payload_q);
  assign wdata        = payload_wide[DATA_WIDTH-1:0];

  tcpq_ring #(
    .DEPTH      (NORMAL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CW         (NCW)
  ) u_normal_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (n_ctrl),
    .wdata_i (wdata),
    .count_o (n_count),
    .rdata_o (n_rdata)
  );

  tcpq_ring #(
    .DEPTH      (URGENT_DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CW         (UCW)
  ) u_urgent_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (u_ctrl),
    .wdata_i (wdata),
    .count_o (u_count),
    .rdata_o (u_rdata)
  );

  // ---------------- operation decode ----------------
  logic [SW-1:0] nlim, ulim;        // effective limits: min(register, depth)
  logic [SW-1:0] n_cnt, u_cnt;
  logic [SW-1:0] n_next, u_next;    // occupancy after this operation
  logic          n_full, u_full;
  status_e       status_d;

  assign nlim = (SW'(normal_limit_q) < SW'(NORMAL_DEPTH)) ? SW'(normal_limit_q)
                                                          : SW'(NORMAL_DEPTH);
  assign ulim = (SW'(urgent_limit_q) < SW'(URGENT_DEPTH)) ? SW'(urgent_limit_q)
                                                          : SW'(URGENT_DEPTH);
  assign n_cnt  = SW'(n_count);
  assign u_cnt  = SW'(u_count);
  assign n_full = (n_cnt >= nlim);
  assign u_full = (u_cnt >= ulim);

  always_comb begin
    n_ctrl   = '0;
    u_ctrl   = '0;
    status_d = ST_OK;
    unique case (in_op_q)
      OP_SEND_NORMAL: begin
        if (n_full) status_d = ST_FULL;
        else        n_ctrl.push = fire;
      end
      OP_SEND_URGENT: begin
        if (u_full) status_d = ST_FULL;
        else        u_ctrl.push = fire;
      end
      OP_RECEIVE: begin
        // Urgent class always drains first
        if (u_cnt != '0)      u_ctrl.pop = fire;
        else if (n_cnt != '0) n_ctrl.pop = fire;
        else                  status_d   = ST_EMPTY;
      end
      OP_FLUSH_NORMAL: n_ctrl.clear = fire;
      OP_FLUSH_URGENT: u_ctrl.clear = fire;
      OP_FLUSH_ALL: begin
        n_ctrl.clear = fire;
        u_ctrl.clear = fire;
      end
      default: ;  // unused opcodes: no change, status ok
    endcase
  end

  always_comb begin
    n_next = n_cnt;
    u_next = u_cnt;
    if (n_ctrl.clear)     n_next = '0;
    else if (n_ctrl.push) n_next = n_cnt + SW'(1);
    else if (n_ctrl.pop)  n_next = n_cnt - SW'(1);
    if (u_ctrl.clear)     u_next = '0;
    else if (u_ctrl.push) u_next = u_cnt + SW'(1);
    else if (u_ctrl.pop)  u_next = u_cnt - SW'(1);
  end

  // Free counts saturate at zero when a limit was lowered below occupancy
  logic [SW-1:0] lim_sum, held_sum;
  logic [SW-1:0] free_total_d, free_urgent_d, free_normal_d;

  assign lim_sum       = nlim + ulim;
  assign held_sum      = n_next + u_next;
  assign free_total_d  = (lim_sum > held_sum) ? (lim_sum - held_sum) : '0;
  assign free_urgent_d = (ulim > u_next) ? (ulim - u_next) : '0;
  assign free_normal_d = (nlim > n_next) ? (nlim - n_next) : '0;

  // ---------------- result register ----------------
  status_e                  status_q;
  logic                     took_urgent_q, took_normal_q;
  logic [FREE_TOTAL_W-1:0]  free_total_q;
  logic [FREE_URGENT_W-1:0] free_urgent_q;
  logic [FREE_NORMAL_W-1:0] free_normal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q      <= status_d;
      took_urgent_q <= u_ctrl.pop;
      took_normal_q <= n_ctrl.pop;
      free_total_q  <= free_total_d[FREE_TOTAL_W-1:0];
      free_urgent_q <= free_urgent_d[FREE_URGENT_W-1:0];
      free_normal_q <= free_normal_d[FREE_NORMAL_W-1:0];
    end
  end

  // Received word comes from the ring's read register, which only moves on pop
  logic [DATA_WIDTH-1:0] msg_sel;
  logic [WIDE-1:0]       msg_wide;

  always_comb begin
    if (took_urgent_q)      msg_sel = u_rdata;
    else if (took_normal_q) msg_sel = n_rdata;
    else                    msg_sel = '0;
  end
  assign msg_wide = WIDE'(msg_sel);

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign message_out_o   = msg_wide[PAYLOAD_W-1:0];
  assign is_urgent_out_o = took_urgent_q;
  assign free_total_o    = free_total_q;
  assign free_urgent_o   = free_urgent_q;
  assign free_normal_o   = free_normal_q;

  // ---------------- assertions ----------------
  // A normal word is only taken while the urgent class is empty
  `TCPQ_ASSERT_IMP(a_normal_pop_urgent_empty, n_ctrl.pop, u_cnt == '0)
  // Only an ok receive carries a message or the urgent flag
  `TCPQ_ASSERT_IMP(a_idle_fields_zero, out_valid_q && (status_q != ST_OK), !took_urgent_q && !took_normal_q)
  // Flush all empties both classes on the following cycle
  `TCPQ_ASSERT_NEXT(a_flush_all_empties, fire && (in_op_q == OP_FLUSH_ALL), (n_count == '0) && (u_count == '0))
  // Occupancy never exceeds store depth
  `TCPQ_ASSERT_IMP(a_count_in_depth, out_valid_q, (n_cnt <= SW'(NORMAL_DEPTH)) && (u_cnt <= SW'(URGENT_DEPTH)))

endmodule

// ----- design/tcpq_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_ring
// One message class: ring store with head pointer, fill count and a
// registered read port loaded on pop.
// ----------------------------------------------------------------------------
module tcpq_ring #(
  parameter int unsigned DEPTH      = tcpq_pkg::NORMAL_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = tcpq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned CW         = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcpq_pkg::ring_ctrl_t  ctrl_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  output logic [CW-1:0]         count_o,
  output logic [DATA_WIDTH-1:0] rdata_o
);
  import tcpq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = ((AW > CW) ? AW : CW) + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [PW-1:0]         tail_sum;
  logic [PW-1:0]         tail_wrap;
  logic [AW:0]           head_inc;

  // Tail = (head + count) mod DEPTH; sum stays below 2*DEPTH on a push
  assign tail_sum  = PW'(head_q) + PW'(count_q);
  assign tail_wrap = (tail_sum >= PW'(DEPTH)) ? (tail_sum - PW'(DEPTH)) : tail_sum;
  assign head_inc  = (AW + 1)'(head_q) + (AW + 1)'(1);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (ctrl_i.push) begin
      count_d = count_q + CW'(1);
    end else if (ctrl_i.pop) begin
      head_d  = (head_inc == (AW + 1)'(DEPTH)) ? '0 : head_inc[AW-1:0];
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_wrap[AW-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      rdata_q <= mem[head_q];
    end
  end

  assign count_o = count_q;
  assign rdata_o = rdata_q;

endmodule
